// File: rtl/core/positional_list_engine_macros.svh
// positional_list_engine_macros.svh: assertion macros for the list engine.
// Depends on nothing; included by files that assert.
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH
// Assert that a property holds on every clock edge out of reset.
`define PLE_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Assert a property, checked during reset as well.
`define PLE_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/core/ple_pkg.sv
// ple_pkg: types, codes and sizes for the positional list engine.
// Depends on nothing.
package ple_pkg;
   localparam int DepthDefault = 256;
   localparam int ElemWidthDefault = 32;
   localparam int PosWidth = 9;
   localparam int ValWidth = 32;

   localparam logic [2:0] MODE_INSERT = 3'd0;
   localparam logic [2:0] MODE_DELETE = 3'd1;
   localparam logic [2:0] MODE_GET    = 3'd2;
   localparam logic [2:0] MODE_SEARCH = 3'd3;
   localparam logic [2:0] MODE_SORT   = 3'd4;
   localparam logic [2:0] MODE_DEDUP  = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_WRONGPOS = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [2:0]          mode;
      logic [PosWidth-1:0] position;
      logic [ValWidth-1:0] value_in;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [ValWidth-1:0] value_out;
      logic [PosWidth-1:0] found_position;
      logic [PosWidth-1:0] count;
   } rsp_type;

   // Datapath operations ordered by the controller.
   typedef enum logic [3:0] {
      OP_NONE,      // hold
      OP_LATCH,     // capture request, load scan index
      OP_RD_A,      // read store at index a
      OP_RD_B,      // read store at index b
      OP_CAP_A,     // capture read data into reg a
      OP_CAP_B,     // capture read data into reg b
      OP_WR_A_AT_B, // write reg a at index b
      OP_WR_B_AT_A, // write reg b at index a
      OP_WR_VAL,    // write request value at index a
      OP_CP_B_TO_A, // copy reg b into reg a
      OP_CP_A_TO_B  // copy reg a into reg b
   } op_type;

   // Controller to datapath.
   typedef struct packed {
      op_type     op;
      logic [2:0] idx_sel;  // index update code
      logic       len_inc;
      logic       len_dec;
      logic       len_keep; // length = a + 1 (dedup)
      logic       cap_out;  // capture read data into value_out
      logic       found_set;// found = a + 1
   } dp_cmd_type;

   localparam logic [2:0] IX_HOLD     = 3'd0;
   localparam logic [2:0] IX_A_DEC    = 3'd1;
   localparam logic [2:0] IX_A_INC    = 3'd2;
   localparam logic [2:0] IX_B_INC    = 3'd3;
   localparam logic [2:0] IX_B_FROM_A = 3'd4; // b = a + 1, min = a
   localparam logic [2:0] IX_MIN_B    = 3'd5; // min = b, b advances
   localparam logic [2:0] IX_B_FROM_M = 3'd6; // b = min

   // Datapath to controller.
   typedef struct packed {
      logic [2:0] mode;
      logic       empty;
      logic       full;
      logic       pos_bad_ins;
      logic       pos_bad_rd;
      logic       a_zero;    // index a is 0
      logic       a_at_pos;  // index a == position-1
      logic       a_last;    // a + 1 >= length
      logic       b_end;     // b >= length
      logic       eq_ab;     // reg a == reg b
      logic       eq_val;    // reg a == request value
      logic       b_lt_a;    // reg b < reg a
      logic       len_small; // length < 2
   } dp_stat_type;
endpackage

// File: rtl/core/positional_list_engine.sv
// positional_list_engine: top level of the bounded positional list.
// Depends on ple_pkg, ple_control, ple_datapath and ple_ram.
//
// Usage:
//   Drive req_item and raise start; the item is taken at the edge where
//   start is high and busy is low. busy falls in the cycle the result is out.
//   The result appears on rsp_item for exactly one cycle with done high;
//   the receiver cannot stall, so it must take it then.
// Operations are paced by the single-port element store: one access per step,
//   and each entry takes a registered read and then its compare or write;
//   get reads one entry, insert and delete move entries one at a time,
//   search scans entries one at a time, sort scans the unsorted part once
//   per position, and dedup scans each entry once.
// Reset clears the length and the controller; store contents are left
//   undefined and are never read before written.
// One item is in flight at a time; the next may be taken in the result cycle.
module positional_list_engine #(
   parameter int DEPTH = ple_pkg::DepthDefault,
   parameter int ELEM_WIDTH = ple_pkg::ElemWidthDefault
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ple_pkg::req_type req_item,
   output logic             done,
   output ple_pkg::rsp_type rsp_item
);
   ple_pkg::dp_cmd_type  cmd;
   ple_pkg::dp_stat_type stat;
   logic [1:0]           status;
   logic [ple_pkg::ValWidth-1:0] out_value;
   logic [ple_pkg::PosWidth-1:0] out_found, out_count;

   ple_control u_ctl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .done(done),
      .status(status), .stat(stat), .cmd(cmd)
   );

   ple_datapath #(.DEPTH(DEPTH), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .req_item(req_item), .cmd(cmd), .stat(stat),
      .out_value(out_value), .out_found(out_found), .out_count(out_count)
   );

   // Assemble the result item.
   always_comb begin
      rsp_item.status         = status;
      rsp_item.value_out      = out_value;
      rsp_item.found_position = out_found;
      rsp_item.count          = out_count;
   end
endmodule

// File: rtl/core/ple_ram.sv
// ple_ram: generic single-port RAM with registered read.
// Depends on nothing.
module ple_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   // Write or read one entry a cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_ff <= mem[addr];
   end
   assign rd_data = rd_ff;
endmodule

// File: rtl/core/ple_datapath.sv
// ple_datapath: length, indexes, working registers and element store.
// Depends on ple_pkg and ple_ram.
module ple_datapath #(
   parameter int DEPTH = ple_pkg::DepthDefault,
   parameter int ELEM_WIDTH = ple_pkg::ElemWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ple_pkg::req_type      req_item,
   input  ple_pkg::dp_cmd_type   cmd,
   output ple_pkg::dp_stat_type  stat,
   output logic [ple_pkg::ValWidth-1:0] out_value,
   output logic [ple_pkg::PosWidth-1:0] out_found,
   output logic [ple_pkg::PosWidth-1:0] out_count
);
   localparam int AW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH + 1);
   localparam int XW = LW + 1;

   logic [LW-1:0]         len_ff, len_in;
   logic [XW-1:0]         a_ff, a_in, b_ff, b_in, m_ff, m_in;
   logic [ELEM_WIDTH-1:0] ra_ff, ra_in, rb_ff, rb_in;
   ple_pkg::req_type      req_ff, req_in;
   logic [ple_pkg::ValWidth-1:0] vout_ff, vout_in;
   logic [ple_pkg::PosWidth-1:0] found_ff, found_in;
   logic [ELEM_WIDTH-1:0] rd_data, wr_data, val;
   logic [AW-1:0]         addr;
   logic                  wr_en;
   logic [XW-1:0]         len_x, pos_x;

   assign len_x = XW'(len_ff);
   assign pos_x = XW'(req_ff.position);
   assign val   = ELEM_WIDTH'(req_ff.value_in);

   ple_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_data), .rd_data(rd_data)
   );

   // Drive the store port from the command.
   always_comb begin
      wr_en   = 1'b0;
      addr    = a_ff[AW-1:0];
      wr_data = ra_ff;
      case (cmd.op)
         ple_pkg::OP_RD_B:      addr = b_ff[AW-1:0];
         ple_pkg::OP_WR_A_AT_B: begin wr_en = 1'b1; addr = b_ff[AW-1:0]; end
         ple_pkg::OP_WR_B_AT_A: begin wr_en = 1'b1; wr_data = rb_ff; end
         ple_pkg::OP_WR_VAL:    begin wr_en = 1'b1; wr_data = val; end
         default: ;
      endcase
   end

   // Advance registers.
   always_comb begin
      len_in = len_ff; a_in = a_ff; b_in = b_ff; m_in = m_ff;
      ra_in = ra_ff; rb_in = rb_ff; req_in = req_ff;
      vout_in = vout_ff; found_in = found_ff;
      if (cmd.op == ple_pkg::OP_LATCH) begin
         req_in   = req_item;
         vout_in  = '0;
         found_in = '0;
         a_in     = '0;
         b_in     = '0;
      end
      if (cmd.op == ple_pkg::OP_CAP_A) ra_in = rd_data;
      if (cmd.op == ple_pkg::OP_CAP_B) rb_in = rd_data;
      if (cmd.op == ple_pkg::OP_CP_B_TO_A) ra_in = rb_ff;
      if (cmd.op == ple_pkg::OP_CP_A_TO_B) rb_in = ra_ff;
      case (cmd.idx_sel)
         ple_pkg::IX_A_DEC:    a_in = a_ff - 1'b1;
         ple_pkg::IX_A_INC:    a_in = a_ff + 1'b1;
         ple_pkg::IX_B_INC:    b_in = b_ff + 1'b1;
         ple_pkg::IX_B_FROM_A: begin b_in = a_ff + 1'b1; m_in = a_ff; end
         ple_pkg::IX_MIN_B:    begin m_in = b_ff; b_in = b_ff + 1'b1; end
         ple_pkg::IX_B_FROM_M: b_in = m_ff;
         default: ;
      endcase
      // Load a from length or position at the start of a walk.
      if (cmd.op == ple_pkg::OP_LATCH) begin
         case (req_item.mode)
            ple_pkg::MODE_INSERT, ple_pkg::MODE_SEARCH: a_in = len_x;
            ple_pkg::MODE_DELETE, ple_pkg::MODE_GET:
               a_in = XW'(req_item.position) - 1'b1;
            default: a_in = '0;
         endcase
      end
      if (cmd.len_inc)   len_in = len_ff + 1'b1;
      if (cmd.len_dec)   len_in = len_ff - 1'b1;
      if (cmd.len_keep)  len_in = LW'(a_ff + 1'b1);
      if (cmd.cap_out)   vout_in = ple_pkg::ValWidth'(rd_data);
      if (cmd.found_set) found_in = ple_pkg::PosWidth'(a_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
      a_ff <= a_in; b_ff <= b_in; m_ff <= m_in;
      ra_ff <= ra_in; rb_ff <= rb_in; req_ff <= req_in;
      vout_ff <= vout_in; found_ff <= found_in;
   end

   // Report status.
   always_comb begin
      stat.mode        = req_ff.mode;
      stat.empty       = (len_ff == '0);
      stat.full        = (len_x >= XW'(DEPTH));
      stat.pos_bad_ins = (pos_x == '0) || (pos_x > len_x + 1'b1);
      stat.pos_bad_rd  = (pos_x == '0) || (pos_x > len_x);
      stat.a_zero      = (a_ff == '0);
      stat.a_at_pos    = (a_ff + 1'b1 == pos_x);
      stat.a_last      = (a_ff + 1'b1 >= len_x);
      stat.b_end       = (b_ff >= len_x);
      stat.eq_ab       = (ra_ff == rb_ff);
      stat.eq_val      = (ra_ff == val);
      stat.b_lt_a      = (rb_ff < ra_ff);
      stat.len_small   = (len_x < 2);
   end

   assign out_value = vout_ff;
   assign out_found = found_ff;
   assign out_count = ple_pkg::PosWidth'(len_ff);
endmodule

// File: rtl/core/ple_control.sv
// ple_control: sequencer for the list operations.
// Depends on ple_pkg and the macros header.
`include "positional_list_engine_macros.svh"
module ple_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 done,
   output logic [1:0]           status,
   input  ple_pkg::dp_stat_type stat,
   output ple_pkg::dp_cmd_type  cmd
);
   typedef enum logic [5:0] {
      S_IDLE, S_DISPATCH,
      S_INS_TEST, S_INS_RD, S_INS_W1, S_INS_CAP, S_INS_WR, S_INS_PUT,
      S_GET_RD, S_GET_W, S_GET_CAP, S_DEL_TEST, S_DEL_RD, S_DEL_W,
      S_DEL_CAP, S_DEL_WR,
      S_SR_TEST, S_SR_RD, S_SR_W, S_SR_CAP, S_SR_CMP,
      S_SO_OUTER, S_SO_RDA, S_SO_WA, S_SO_CAPA, S_SO_INNER, S_SO_RDB, S_SO_WB,
      S_SO_CAPB, S_SO_CMP, S_SO_KEEP,
      S_SO_RDO, S_SO_WO, S_SO_CAPO, S_SO_WRO, S_SO_SWAP,
      S_DONE
   } state_type;
   // Dedup reuses the sort fetch states with a separate flag.

   state_type  state_ff;
   logic [1:0] status_ff;
   logic       dedup_ff;
   logic       done_ff;

   // Sequence one item; commands are decoded from state and status.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; status_ff <= ple_pkg::ST_OK;
         dedup_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (start) begin
               state_ff <= S_DISPATCH; status_ff <= ple_pkg::ST_OK;
            end
            S_DISPATCH: begin
               dedup_ff <= 1'b0;
               case (stat.mode)
                  ple_pkg::MODE_INSERT:
                     if (stat.full) begin
                        status_ff <= ple_pkg::ST_FULL; state_ff <= S_DONE;
                     end else if (stat.pos_bad_ins) begin
                        status_ff <= ple_pkg::ST_WRONGPOS; state_ff <= S_DONE;
                     end else state_ff <= S_INS_TEST;
                  ple_pkg::MODE_DELETE, ple_pkg::MODE_GET:
                     if (stat.empty) begin
                        status_ff <= ple_pkg::ST_EMPTY; state_ff <= S_DONE;
                     end else if (stat.pos_bad_rd) begin
                        status_ff <= ple_pkg::ST_WRONGPOS; state_ff <= S_DONE;
                     end else state_ff <= S_GET_RD;
                  ple_pkg::MODE_SEARCH: state_ff <= S_SR_TEST;
                  ple_pkg::MODE_SORT: state_ff <= stat.len_small ? S_DONE : S_SO_OUTER;
                  ple_pkg::MODE_DEDUP: begin
                     dedup_ff <= 1'b1;
                     state_ff <= stat.len_small ? S_DONE : S_SO_RDA;
                  end
                  default: state_ff <= S_DONE;
               endcase
            end
            // Insert: shift from the top down to position, then put value.
            S_INS_TEST: state_ff <= stat.a_at_pos ? S_INS_PUT : S_INS_RD;
            S_INS_RD:   state_ff <= S_INS_W1;
            S_INS_W1:   state_ff <= S_INS_CAP;
            S_INS_CAP:  state_ff <= S_INS_WR;
            S_INS_WR:   state_ff <= S_INS_TEST;
            S_INS_PUT:  state_ff <= S_DONE;
            // Get/delete: read entry, then shift the tail down for delete.
            S_GET_RD:   state_ff <= S_GET_W;
            S_GET_W:    state_ff <= S_GET_CAP;
            S_GET_CAP:  state_ff <= (stat.mode == ple_pkg::MODE_DELETE) ? S_DEL_TEST : S_DONE;
            S_DEL_TEST: state_ff <= stat.a_last ? S_DONE : S_DEL_RD;
            S_DEL_RD:   state_ff <= S_DEL_W;
            S_DEL_W:    state_ff <= S_DEL_CAP;
            S_DEL_CAP:  state_ff <= S_DEL_WR;
            S_DEL_WR:   state_ff <= S_DEL_TEST;
            // Search: walk down from the top.
            S_SR_TEST:  state_ff <= stat.a_zero ? S_DONE : S_SR_RD;
            S_SR_RD:    state_ff <= S_SR_W;
            S_SR_W:     state_ff <= S_SR_CAP;
            S_SR_CAP:   state_ff <= S_SR_CMP;
            S_SR_CMP:   state_ff <= stat.eq_val ? S_DONE : S_SR_TEST;
            // Sort outer loop; dedup enters at the fetch of the kept entry.
            S_SO_OUTER: state_ff <= stat.a_last ? S_DONE : S_SO_RDA;
            S_SO_RDA:   state_ff <= S_SO_WA;
            S_SO_WA:    state_ff <= S_SO_CAPA;
            S_SO_CAPA:  state_ff <= S_SO_INNER;
            S_SO_INNER: state_ff <= stat.b_end ? (dedup_ff ? S_DONE : S_SO_RDO)
                                               : S_SO_RDB;
            S_SO_RDB:   state_ff <= S_SO_WB;
            S_SO_WB:    state_ff <= S_SO_CAPB;
            S_SO_CAPB:  state_ff <= S_SO_CMP;
            S_SO_CMP:   state_ff <= (dedup_ff && !stat.eq_ab) ? S_SO_KEEP : S_SO_INNER;
            S_SO_KEEP:  state_ff <= S_SO_INNER;
            // Swap: refetch the entry at a, then write both ends.
            S_SO_RDO:   state_ff <= S_SO_WO;
            S_SO_WO:    state_ff <= S_SO_CAPO;
            S_SO_CAPO:  state_ff <= S_SO_WRO;
            S_SO_WRO:   state_ff <= S_SO_SWAP;
            S_SO_SWAP:  state_ff <= S_SO_OUTER;
            S_DONE: begin
               state_ff <= S_IDLE; done_ff <= 1'b1;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Decode datapath commands.
   always_comb begin
      cmd = '{op: ple_pkg::OP_NONE, idx_sel: ple_pkg::IX_HOLD, len_inc: 1'b0,
              len_dec: 1'b0, len_keep: 1'b0, cap_out: 1'b0, found_set: 1'b0};
      case (state_ff)
         S_IDLE: if (start) cmd.op = ple_pkg::OP_LATCH;
         S_DISPATCH:
            if (stat.mode == ple_pkg::MODE_DEDUP) cmd.idx_sel = ple_pkg::IX_B_FROM_A;
         S_INS_RD:  begin cmd.op = ple_pkg::OP_RD_B; cmd.idx_sel = ple_pkg::IX_A_DEC; end
         S_INS_CAP: begin cmd.op = ple_pkg::OP_CAP_A; cmd.idx_sel = ple_pkg::IX_B_FROM_A; end
         S_INS_WR:  cmd.op = ple_pkg::OP_WR_A_AT_B;
         S_INS_PUT: begin cmd.op = ple_pkg::OP_WR_VAL; cmd.len_inc = 1'b1; end
         S_GET_RD:  cmd.op = ple_pkg::OP_RD_A;
         S_GET_CAP: begin cmd.op = ple_pkg::OP_CAP_A; cmd.cap_out = 1'b1; end
         S_GET_W:   ;
         S_DEL_TEST: begin
            if (!stat.a_last) cmd.idx_sel = ple_pkg::IX_B_FROM_A;
            else cmd.len_dec = 1'b1;
         end
         S_DEL_RD:  cmd.op = ple_pkg::OP_RD_B;
         S_DEL_W:   cmd.op = ple_pkg::OP_RD_B;
         S_DEL_CAP: cmd.op = ple_pkg::OP_CAP_B;
         S_DEL_WR:  begin cmd.op = ple_pkg::OP_WR_B_AT_A; cmd.idx_sel = ple_pkg::IX_A_INC; end
         S_SR_TEST: if (!stat.a_zero) cmd.idx_sel = ple_pkg::IX_A_DEC;
         S_SR_RD:   cmd.op = ple_pkg::OP_RD_A;
         S_SR_CAP:  cmd.op = ple_pkg::OP_CAP_A;
         S_SR_CMP:  cmd.found_set = stat.eq_val;
         S_SO_OUTER: if (!stat.a_last) cmd.idx_sel = ple_pkg::IX_B_FROM_A;
         S_SO_RDA:  cmd.op = ple_pkg::OP_RD_A;
         S_SO_CAPA: cmd.op = ple_pkg::OP_CAP_A;
         S_SO_INNER: begin
            // End of scan: dedup sets the length, sort parks the minimum in reg b.
            if (stat.b_end) begin
               if (dedup_ff) begin
                  cmd.len_keep = 1'b1;
               end else begin
                  cmd.op = ple_pkg::OP_CP_A_TO_B;
                  cmd.idx_sel = ple_pkg::IX_B_FROM_M;
               end
            end
         end
         S_SO_RDB:  cmd.op = ple_pkg::OP_RD_B;
         S_SO_WB:   cmd.op = ple_pkg::OP_RD_B;
         S_SO_CAPB: cmd.op = ple_pkg::OP_CAP_B;
         S_SO_CMP: begin
            if (dedup_ff) begin
               // Keep a new distinct entry: a advances, it becomes the reference.
               if (!stat.eq_ab) begin
                  cmd.op = ple_pkg::OP_CP_B_TO_A;
                  cmd.idx_sel = ple_pkg::IX_A_INC;
               end else begin
                  cmd.idx_sel = ple_pkg::IX_B_INC;
               end
            end else if (stat.b_lt_a) begin
               cmd.op = ple_pkg::OP_CP_B_TO_A;
               cmd.idx_sel = ple_pkg::IX_MIN_B;
            end else begin
               cmd.idx_sel = ple_pkg::IX_B_INC;
            end
         end
         S_SO_KEEP: begin cmd.op = ple_pkg::OP_WR_B_AT_A; cmd.idx_sel = ple_pkg::IX_B_INC; end
         S_SO_RDO:  cmd.op = ple_pkg::OP_RD_A;
         S_SO_WO:   cmd.op = ple_pkg::OP_RD_A;
         S_SO_CAPO: cmd.op = ple_pkg::OP_CAP_A;
         S_SO_WRO:  cmd.op = ple_pkg::OP_WR_A_AT_B;
         S_SO_SWAP: begin cmd.op = ple_pkg::OP_WR_B_AT_A; cmd.idx_sel = ple_pkg::IX_A_INC; end
         S_DONE: ;
         default: ;
      endcase
   end

   assign busy   = (state_ff != S_IDLE);
   assign done   = done_ff;
   assign status = status_ff;

   `PLE_ASSERT(a_done_idle, clock, reset, done |-> !busy, "result while busy")
   `PLE_ASSERT(a_start_leaves_idle, clock, reset, (start && !busy) |=> busy,
               "accepted item did not start")
   `PLE_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> !busy && !done,
                      "not idle after reset")
endmodule
